// ===== rtl/upe_pkg.sv =====
// upe_pkg: shared types, character constants and helpers of the url percent encoder
// no dependencies; used by every file under rtl
package upe_pkg;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_final;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_byte;
		logic       run_end;
		logic       url_end;
	} result_t;

	typedef enum logic [2:0] {
		OP_COPY,
		OP_ESC,
		OP_SP20,
		OP_PLUS,
		OP_MARK,
		OP_DROP
	} op_kind_t;

	typedef struct packed {
		op_kind_t   kind;
		logic [7:0] data;
		logic       run_end;
		logic       url_end;
	} op_t;

	localparam int MODE_W      = 3;
	localparam int MODE_SPACE  = 0;
	localparam int MODE_STRICT = 1;
	localparam int MODE_ASCII  = 2;

	localparam int OP_DEPTH = 4;
	localparam int OP_PTR_W = $clog2(OP_DEPTH);
	localparam int OP_CNT_W = $clog2(OP_DEPTH + 1);

	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_TWO   = 8'h32;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NUL   = 8'h00;

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		logic [7:0] r;
		r = (v < 4'd10) ? (8'h30 + {4'd0, v}) : (8'h41 + {4'd0, v} - 8'd10);
		return r;
	endfunction

endpackage

// ===== rtl/upe_front.sv =====
// upe_front: takes input bytes, keeps the percent lookahead window, and
// classifies one window byte per cycle, while the op queue has room and no '%' is held, into an escape op; uses upe_pkg
module upe_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [upe_pkg::MODE_W-1:0]   mode,
	input  logic                         push,
	output logic                         full,
	input  upe_pkg::item_t               item,
	output logic                         op_push,
	output upe_pkg::op_t                 op,
	input  logic                         op_full
);

	function automatic logic is_hex(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
			(c >= 8'h61 && c <= 8'h66);
	endfunction

	function automatic logic is_alnum(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
			(c >= 8'h61 && c <= 8'h7A);
	endfunction

	function automatic logic is_ctl(input logic [7:0] c);
		return c == 8'h0A || c == 8'h0D || c == 8'h09;
	endfunction

	function automatic logic is_drop(input logic [7:0] c,
			input logic [upe_pkg::MODE_W-1:0] m);
		return !m[upe_pkg::MODE_STRICT] && m[upe_pkg::MODE_ASCII] && is_ctl(c);
	endfunction

	function automatic upe_pkg::op_kind_t classify(input logic [7:0] c,
			input logic [upe_pkg::MODE_W-1:0] m, input logic query, input logic keep);
		upe_pkg::op_kind_t k;
		k = upe_pkg::OP_COPY;
		if (c == upe_pkg::CH_SPACE) begin
			if (m[upe_pkg::MODE_SPACE] || m[upe_pkg::MODE_STRICT])
				k = query ? upe_pkg::OP_PLUS : upe_pkg::OP_SP20;
		end else if (m[upe_pkg::MODE_STRICT]) begin
			if (is_alnum(c) || c == 8'h5F || c == 8'h2A || c == 8'h2E || c == 8'h2C ||
					c == 8'h2D || (c == upe_pkg::CH_PCT && keep))
				k = upe_pkg::OP_COPY;
			else if (query && (c == 8'h26 || c == 8'h3D))
				k = upe_pkg::OP_COPY;
			else if (!query && (c == 8'h5C || c == 8'h2F || c == 8'h3A || c == 8'h3F))
				k = upe_pkg::OP_COPY;
			else
				k = upe_pkg::OP_ESC;
		end else if (m[upe_pkg::MODE_ASCII]) begin
			if (c[7])
				k = upe_pkg::OP_ESC;
			else if (is_ctl(c))
				k = upe_pkg::OP_DROP;
		end
		return k;
	endfunction

	logic [2:0][7:0]   win_q;
	logic [1:0]        cnt_q;
	logic              active_q;
	logic              final_q;
	logic              query_q;
	logic              emitted_q;

	logic              strict;
	logic              adv;
	logic              hold0, hold1, hold2;
	logic              emit1, emit2;
	logic              last;
	logic              keep;
	upe_pkg::op_kind_t kind0;
	logic              drop0;
	logic              step_end;
	logic              set_query;
	logic              acc;
	logic [2:0][7:0]   win_a, win_n;
	logic [1:0]        cnt_a;

	assign strict = mode[upe_pkg::MODE_STRICT];
	assign adv    = active_q && !op_full;

	assign hold0 = strict && win_q[0] == upe_pkg::CH_PCT && cnt_q != 2'd3 && !final_q;
	assign hold1 = strict && win_q[1] == upe_pkg::CH_PCT && !final_q;
	assign hold2 = strict && win_q[2] == upe_pkg::CH_PCT && !final_q;
	assign emit1 = cnt_q >= 2'd2 && !hold1 && !is_drop(win_q[1], mode);
	assign emit2 = cnt_q == 2'd3 && !hold1 && !hold2 && !is_drop(win_q[2], mode);
	assign last  = !(emit1 || emit2);

	always_comb begin
		unique case (cnt_q)
			2'd2:    keep = is_hex(win_q[1]);
			2'd3:    keep = is_hex(win_q[1]) && is_hex(win_q[2]);
			default: keep = 1'b1;
		endcase
	end

	assign kind0     = classify(win_q[0], mode, query_q, keep);
	assign drop0     = kind0 == upe_pkg::OP_DROP;
	assign set_query = strict && !query_q && win_q[0] == 8'h3F;
	assign step_end  = adv && (hold0 || cnt_q == 2'd1);

	assign op_push = adv && !hold0 && (!drop0 || (last && final_q && !emitted_q));
	assign op.kind    = drop0 ? upe_pkg::OP_MARK : kind0;
	assign op.data    = win_q[0];
	assign op.run_end = last;
	assign op.url_end = last && final_q;

	assign full = active_q && !step_end;
	assign acc  = push && !full;

	// window after this cycle's byte, then the new byte appended
	always_comb begin
		win_a = win_q;
		cnt_a = cnt_q;
		if (adv && !hold0) begin
			win_a[0] = win_q[1];
			win_a[1] = win_q[2];
			cnt_a    = cnt_q - 2'd1;
		end
		win_n = win_a;
		if (acc) begin
			unique case (cnt_a)
				2'd0:    win_n[0] = item.in_byte;
				2'd1:    win_n[1] = item.in_byte;
				default: win_n[2] = item.in_byte;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		win_q <= win_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= 2'd0;
			active_q  <= 1'b0;
			final_q   <= 1'b0;
			query_q   <= 1'b0;
			emitted_q <= 1'b0;
		end else begin
			if (acc) begin
				cnt_q     <= cnt_a + 2'd1;
				active_q  <= 1'b1;
				final_q   <= item.in_final;
				emitted_q <= 1'b0;
			end else begin
				cnt_q <= cnt_a;
				if (step_end)
					active_q <= 1'b0;
				if (op_push)
					emitted_q <= 1'b1;
			end
			priority if (step_end && final_q) begin
				query_q <= 1'b0;
			end else if (adv && !hold0 && set_query) begin
				query_q <= 1'b1;
			end
		end
	end

endmodule

// ===== rtl/upe_fifo.sv =====
// upe_fifo: short op queue between the classifier and the expander
// depends on upe_pkg for op_t and the queue depth
module upe_fifo (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr,
	input  upe_pkg::op_t wr_op,
	output logic         full,
	input  logic         rd,
	output upe_pkg::op_t head,
	output logic         empty
);

	upe_pkg::op_t                  mem_q [upe_pkg::OP_DEPTH];
	logic [upe_pkg::OP_PTR_W-1:0]  wptr_q, rptr_q;
	logic [upe_pkg::OP_CNT_W-1:0]  cnt_q;
	logic                          do_wr, do_rd;

	assign full  = cnt_q == upe_pkg::OP_CNT_W'(upe_pkg::OP_DEPTH);
	assign empty = cnt_q == '0;
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign head  = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wptr_q] <= wr_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr)
				wptr_q <= wptr_q + 1'b1;
			if (do_rd)
				rptr_q <= rptr_q + 1'b1;
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ===== rtl/upe_back.sv =====
// upe_back: expands queued ops into output bytes, one per cycle while results are popped, into the
// result register; depends on upe_pkg
module upe_back (
	input  logic             clk,
	input  logic             arst_n,
	input  upe_pkg::op_t     op,
	input  logic             op_valid,
	output logic             op_pop,
	output upe_pkg::result_t result,
	output logic             empty,
	input  logic             pop
);

	upe_pkg::result_t res_q;
	logic             valid_q;
	logic [1:0]       sub_q;
	logic             three;
	logic             last_sub;
	logic             load;
	logic             take;
	upe_pkg::result_t res_n;

	assign three    = op.kind == upe_pkg::OP_ESC || op.kind == upe_pkg::OP_SP20;
	assign last_sub = !three || sub_q == 2'd2;
	assign take     = pop && valid_q;
	assign load     = op_valid && (!valid_q || take);
	assign op_pop   = load && last_sub;

	always_comb begin
		res_n.has_byte = 1'b1;
		res_n.run_end  = op.run_end && last_sub;
		res_n.url_end  = op.url_end && last_sub;
		unique case (op.kind)
			upe_pkg::OP_COPY: res_n.out_byte = op.data;
			upe_pkg::OP_PLUS: res_n.out_byte = upe_pkg::CH_PLUS;
			upe_pkg::OP_SP20: begin
				unique case (sub_q)
					2'd0:    res_n.out_byte = upe_pkg::CH_PCT;
					2'd1:    res_n.out_byte = upe_pkg::CH_TWO;
					default: res_n.out_byte = upe_pkg::CH_ZERO;
				endcase
			end
			upe_pkg::OP_ESC: begin
				unique case (sub_q)
					2'd0:    res_n.out_byte = upe_pkg::CH_PCT;
					2'd1:    res_n.out_byte = upe_pkg::hex_char(op.data[7:4]);
					default: res_n.out_byte = upe_pkg::hex_char(op.data[3:0]);
				endcase
			end
			default: begin
				res_n.out_byte = upe_pkg::CH_NUL;
				res_n.has_byte = 1'b0;
			end
		endcase
	end

	assign result = res_q;
	assign empty  = !valid_q;

	always_ff @(posedge clk) begin
		if (load)
			res_q <= res_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sub_q   <= 2'd0;
		end else begin
			if (load)
				valid_q <= 1'b1;
			else if (take)
				valid_q <= 1'b0;
			if (load)
				sub_q <= last_sub ? 2'd0 : sub_q + 2'd1;
		end
	end

endmodule

// ===== rtl/url_percent_encoder_unit.sv =====
// url_percent_encoder_unit: top level of the url percent encoder
// depends on upe_pkg, upe_front, upe_fifo and upe_back
//
// Bytes of a URL go in on the push side and escaped bytes come out of the
// result queue, one result per cycle at most; a copied byte gives one result,
// an escape or a "%20" gives three, so the result side sets the sustained rate
// of input bytes. The front takes a new byte in the cycle its window drains
// and decides one window byte per cycle while the op queue has room; in strict
// mode a '%' is held until the two bytes after it or the end of the URL are
// seen, so such a byte yields nothing until then. A four-entry op queue sits
// between the front and the output expander. encode_mode is written through
// the cfg channel, which is always ready, and should change only while idle.
module url_percent_encoder_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  upe_pkg::item_t             item,
	output logic                       empty,
	input  logic                       pop,
	output upe_pkg::result_t           result,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [upe_pkg::MODE_W-1:0] cfg_mode
);

	logic [upe_pkg::MODE_W-1:0] mode_q;
	logic                       op_push, op_full, op_pop, op_empty;
	upe_pkg::op_t               op_in, op_head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mode_q <= '0;
		else if (cfg_valid && cfg_ready)
			mode_q <= cfg_mode;
	end

	upe_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.mode    (mode_q),
		.push    (push),
		.full    (full),
		.item    (item),
		.op_push (op_push),
		.op      (op_in),
		.op_full (op_full)
	);

	upe_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (op_push),
		.wr_op  (op_in),
		.full   (op_full),
		.rd     (op_pop),
		.head   (op_head),
		.empty  (op_empty)
	);

	upe_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (op_head),
		.op_valid (!op_empty),
		.op_pop   (op_pop),
		.result   (result),
		.empty    (empty),
		.pop      (pop)
	);

endmodule

// ===== rtl/upe_checker.sv =====
// upe_checker: port-level assertions on the result queue of the encoder
// depends on upe_pkg; bound to url_percent_encoder_unit below
module upe_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             empty,
	input logic             pop,
	input upe_pkg::result_t result
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("result changed while waiting");

	a_marker: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !result.has_byte |->
			result.run_end && result.url_end && result.out_byte == upe_pkg::CH_NUL)
		else $error("bare end marker malformed");

	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.url_end |-> result.run_end)
		else $error("url end without run end");

endmodule

bind url_percent_encoder_unit upe_checker u_upe_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);
